// ===== design/hakg_pkg.sv =====
// Shared types, constants and table function for the hinge angle keyboard gate.
`default_nettype none
package hakg_pkg;

  localparam int TABLE_ENTRIES_DEF = 91;
  localparam int ANGLE_STEPS_DEF   = 361;
  localparam int FRAC_BITS_DEF     = 15;

  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam longint unsigned ONE_Q30     = 64'd1 << 30;

  localparam int RAD_W      = 64;
  localparam int ROOT_W     = 32;
  localparam int ROOT_STEPS = 32;
  localparam int MAG_W      = 16;
  localparam int SUM_W      = 32;
  localparam int NUM_COMP   = 6;

  localparam logic [8:0]  ANGLE_LOW_RST  = 9'd40;
  localparam logic [8:0]  ANGLE_HIGH_RST = 9'd230;
  localparam logic [14:0] TILT_LIMIT_RST = 15'd32113;

  localparam logic [1:0] CFG_ANGLE_LOW  = 2'd0;
  localparam logic [1:0] CFG_ANGLE_HIGH = 2'd1;
  localparam logic [1:0] CFG_TILT_LIMIT = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SQUARE,
    S_ROOT_K,
    S_ROOT_P,
    S_DIV,
    S_SEARCH,
    S_DONE
  } state_t;

  typedef enum logic {
    OP_ROOT,
    OP_DIV
  } op_t;

  typedef struct packed {
    logic start;
    op_t  op;
  } unit_req_t;

  typedef struct packed {
    logic              done;
    logic              busy;
    logic [ROOT_W-1:0] result;
  } unit_resp_t;

  function automatic longint unsigned sine_q30(input longint unsigned x);
    longint unsigned x2;
    longint unsigned h;
    longint unsigned t;
    x2 = (x * x) >> 30;
    h  = ONE_Q30;
    t  = ((h * x2) >> 30) / 156;
    h  = (t >= ONE_Q30) ? 64'd0 : ONE_Q30 - t;
    t  = ((h * x2) >> 30) / 110;
    h  = (t >= ONE_Q30) ? 64'd0 : ONE_Q30 - t;
    t  = ((h * x2) >> 30) / 72;
    h  = (t >= ONE_Q30) ? 64'd0 : ONE_Q30 - t;
    t  = ((h * x2) >> 30) / 42;
    h  = (t >= ONE_Q30) ? 64'd0 : ONE_Q30 - t;
    t  = ((h * x2) >> 30) / 20;
    h  = (t >= ONE_Q30) ? 64'd0 : ONE_Q30 - t;
    t  = ((h * x2) >> 30) / 6;
    h  = (t >= ONE_Q30) ? 64'd0 : ONE_Q30 - t;
    return (x * h) >> 30;
  endfunction

endpackage
`default_nettype wire

// ===== design/hakg_rootdiv.sv =====
// Shared iterative square root and divide unit, one bit per cycle.
`default_nettype none
module hakg_rootdiv #(
  parameter int FRAC_BITS = hakg_pkg::FRAC_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire hakg_pkg::unit_req_t           req,
  input  wire logic [hakg_pkg::RAD_W-1:0]    radicand,
  input  wire logic [hakg_pkg::MAG_W-1:0]    dividend,
  input  wire logic [hakg_pkg::ROOT_W-1:0]   divisor,
  output hakg_pkg::unit_resp_t               resp
);

  localparam int RW = hakg_pkg::ROOT_W;
  localparam int AW = RW + 4;
  localparam logic [RW-1:0] UNIT = RW'(64'd1 << FRAC_BITS);

  logic             busy;
  logic             done;
  logic [5:0]       cnt;
  hakg_pkg::op_t    op_r;
  logic [AW-1:0]    acc;
  logic [RW-1:0]    root;
  logic [hakg_pkg::RAD_W-1:0] rad;

  logic [AW-1:0]    opa;
  logic [AW-1:0]    opb;
  logic [AW:0]      diff;
  logic             take;
  logic             ovf;

  always_comb begin
    if (op_r == hakg_pkg::OP_ROOT) begin
      opa = {acc[AW-3:0], rad[hakg_pkg::RAD_W-1 -: 2]};
      opb = AW'({root, 2'b01});
    end else begin
      opa = {acc[AW-2:0], 1'b0};
      opb = AW'(divisor);
    end
    diff = {1'b0, opa} - {1'b0, opb};
    take = !diff[AW];
    ovf  = RW'({dividend, 14'b0}) >= divisor;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        if (req.op == hakg_pkg::OP_ROOT) begin
          cnt  <= 6'(hakg_pkg::ROOT_STEPS);
          busy <= 1'b1;
        end else if (divisor == '0 || ovf) begin
          done <= 1'b1;
        end else begin
          cnt  <= 6'(FRAC_BITS + 1);
          busy <= 1'b1;
        end
      end else if (busy) begin
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      op_r <= req.op;
      rad  <= radicand;
      if (req.op == hakg_pkg::OP_ROOT) begin
        acc  <= '0;
        root <= '0;
      end else begin
        acc  <= AW'({dividend, 14'b0});
        root <= (divisor == '0) ? '0 : (ovf ? UNIT : '0);
      end
    end else if (busy) begin
      acc  <= take ? diff[AW-1:0] : opa;
      root <= {root[RW-2:0], take};
      rad  <= rad << 2;
    end
  end

  assign resp.done   = done;
  assign resp.busy   = busy;
  assign resp.result = (op_r == hakg_pkg::OP_DIV && root > UNIT) ? UNIT : root;

endmodule
`default_nettype wire

// ===== design/hakg_search.sv =====
// Pipelined rotate-and-compare search over all angle steps.
`default_nettype none
module hakg_search #(
  parameter int TABLE_ENTRIES = hakg_pkg::TABLE_ENTRIES_DEF,
  parameter int ANGLE_STEPS   = hakg_pkg::ANGLE_STEPS_DEF,
  parameter int FRAC_BITS     = hakg_pkg::FRAC_BITS_DEF,
  localparam int CW = FRAC_BITS + 2,
  localparam int IW = $clog2(ANGLE_STEPS)
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  input  wire logic signed [CW-1:0] kx,
  input  wire logic signed [CW-1:0] kz,
  input  wire logic signed [CW-1:0] px,
  input  wire logic signed [CW-1:0] pz,
  output logic                      done,
  output logic [IW-1:0]             best_i
);

  localparam int Q  = TABLE_ENTRIES - 1;
  localparam int TW = FRAC_BITS + 1;
  localparam int JW = $clog2(TABLE_ENTRIES);
  localparam int MW = $clog2(4 * Q);
  localparam int PW = 2 * CW;
  localparam int DW = 2 * FRAC_BITS + 3;
  localparam int SH = 30 - FRAC_BITS;
  localparam longint unsigned UNIT = 64'd1 << FRAC_BITS;

  logic [TW-1:0] tab [TABLE_ENTRIES];

  for (genvar k = 0; k < TABLE_ENTRIES; k++) begin : g_tab
    localparam longint unsigned X  = (hakg_pkg::HALF_PI_Q30 * k + Q / 2) / Q;
    localparam longint unsigned S0 = (hakg_pkg::sine_q30(X) + ((64'd1 << SH) >> 1)) >> SH;
    localparam longint unsigned S1 = (S0 > UNIT) ? UNIT : S0;
    localparam longint unsigned SV = (k == 0) ? 64'd0 : ((k == Q) ? UNIT : S1);
    assign tab[k] = TW'(SV);
  end

  logic          issuing;
  logic [IW-1:0] i;
  logic [MW-1:0] m;
  logic [MW-1:0] jm;
  logic [JW-1:0] jj;
  logic          cn;
  logic          sn;
  logic [TW-1:0] c_raw;
  logic [TW-1:0] s_raw;

  logic                 v1, last1, v2, last2;
  logic [IW-1:0]        i1, i2;
  logic signed [CW-1:0] c1, s1;
  logic signed [PW-1:0] pa, pb, pc, pd;
  logic signed [DW-1:0] d1, d2;
  logic [DW-1:0]        cost;
  logic [DW-1:0]        best;

  always_comb begin
    priority if (m <= MW'(Q)) begin
      jm = m;
      cn = 1'b0;
      sn = 1'b0;
    end else if (m <= MW'(2 * Q)) begin
      jm = MW'(2 * Q) - m;
      cn = 1'b1;
      sn = 1'b0;
    end else if (m <= MW'(3 * Q)) begin
      jm = m - MW'(2 * Q);
      cn = 1'b1;
      sn = 1'b1;
    end else begin
      jm = MW'(4 * Q) - m;
      cn = 1'b0;
      sn = 1'b1;
    end
    jj    = JW'(jm);
    c_raw = tab[JW'(Q) - jj];
    s_raw = tab[jj];
  end

  always_comb begin
    d1   = $signed(DW'(pa)) - $signed(DW'(pb)) + ($signed(DW'(px)) <<< FRAC_BITS);
    d2   = $signed(DW'(pc)) + $signed(DW'(pd)) + ($signed(DW'(pz)) <<< FRAC_BITS);
    cost = (d1[DW-1] ? DW'(-d1) : DW'(d1)) + (d2[DW-1] ? DW'(-d2) : DW'(d2));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      issuing <= 1'b0;
      v1      <= 1'b0;
      v2      <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= v2 && last2;
      v1   <= issuing;
      v2   <= v1;
      if (start) begin
        issuing <= 1'b1;
      end else if (issuing && i == IW'(ANGLE_STEPS - 1)) begin
        issuing <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      i    <= '0;
      m    <= '0;
      best <= '1;
    end else if (issuing) begin
      i <= i + IW'(1);
      m <= (m == MW'(4 * Q - 1)) ? '0 : m + MW'(1);
    end
    i1    <= i;
    last1 <= (i == IW'(ANGLE_STEPS - 1));
    c1    <= cn ? -$signed({1'b0, c_raw}) : $signed({1'b0, c_raw});
    s1    <= sn ? -$signed({1'b0, s_raw}) : $signed({1'b0, s_raw});
    i2    <= i1;
    last2 <= last1;
    pa    <= c1 * kx;
    pb    <= s1 * kz;
    pc    <= c1 * kz;
    pd    <= s1 * kx;
    if (v2 && !start && cost < best) begin
      best   <= cost;
      best_i <= i2;
    end
  end

endmodule
`default_nettype wire

// ===== design/hinge_angle_keyboard_gate.sv =====
// Top level: sequencer, registers and output stage of the hinge angle keyboard gate.
//
// For each sample the accepting cycle comes first. The six axis components are then squared in
// turn through one multiplier and summed per sensor. The shared root/divide unit then takes
// the two square roots and the six normalizing divides; a divide skips its iterations for a
// zero vector or a clipped quotient. The rotate-and-compare pipeline then checks one angle per
// cycle, and the output register is loaded once it reports. A wake request skips the arithmetic
// and goes straight to the output register. in_stall is high while an item is in work; a
// finished result waits in the output register until taken, and a stalled output holds the
// item in its done state until the output is free.
`default_nettype none
module hinge_angle_keyboard_gate #(
  parameter int TABLE_ENTRIES = hakg_pkg::TABLE_ENTRIES_DEF,
  parameter int ANGLE_STEPS   = hakg_pkg::ANGLE_STEPS_DEF,
  parameter int FRAC_BITS     = hakg_pkg::FRAC_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic               kind,
  input  wire logic signed [11:0] kb_x,
  input  wire logic signed [11:0] kb_y,
  input  wire logic signed [11:0] kb_z,
  input  wire logic signed [15:0] pad_x,
  input  wire logic signed [15:0] pad_y,
  input  wire logic signed [15:0] pad_z,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [8:0]              hinge_angle,
  output logic                    angle_valid,
  output logic                    kb_enable,
  output logic                    write_issued,
  input  wire logic               cfg_we,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [14:0]        cfg_data
);

  localparam int CW  = FRAC_BITS + 2;
  localparam int QW  = FRAC_BITS + 1;
  localparam int IW  = $clog2(ANGLE_STEPS);
  localparam int XW  = (IW > 9) ? IW : 9;
  localparam int TCW = FRAC_BITS + 16;
  localparam int MW  = hakg_pkg::MAG_W;
  localparam int SW  = hakg_pkg::SUM_W;
  localparam int RW  = hakg_pkg::ROOT_W;

  hakg_pkg::state_t     state, state_next;
  hakg_pkg::unit_req_t  unit_req;
  hakg_pkg::unit_resp_t unit_resp;

  logic [8:0]  angle_low;
  logic [8:0]  angle_high;
  logic [14:0] tilt_limit;
  logic        kb_enabled;

  logic          wake;
  logic [2:0]    comp;
  logic          sent;
  logic [MW-1:0] mag [hakg_pkg::NUM_COMP];
  logic          neg [hakg_pkg::NUM_COMP];
  logic [QW-1:0] qn  [hakg_pkg::NUM_COMP];
  logic [SW-1:0] sk, sp;
  logic [RW-1:0] rk, rp;
  logic [2*MW-1:0] sq;

  logic          accept;
  logic          out_free;
  logic          load_out;
  logic          srch_start;
  logic          srch_done;
  logic [IW-1:0] best_i;

  logic signed [CW-1:0] kx_n, kz_n, px_n, pz_n;
  logic [QW-1:0]        err;
  logic                 valid_c;
  logic                 en_c;

  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign sq       = mag[comp] * mag[comp];

  always_comb begin
    state_next = state;
    unique case (state)
      hakg_pkg::S_IDLE:   if (in_valid) state_next = kind ? hakg_pkg::S_DONE : hakg_pkg::S_SQUARE;
      hakg_pkg::S_SQUARE: if (comp == 3'd5) state_next = hakg_pkg::S_ROOT_K;
      hakg_pkg::S_ROOT_K: if (unit_resp.done) state_next = hakg_pkg::S_ROOT_P;
      hakg_pkg::S_ROOT_P: if (unit_resp.done) state_next = hakg_pkg::S_DIV;
      hakg_pkg::S_DIV:    if (unit_resp.done && comp == 3'd5) state_next = hakg_pkg::S_SEARCH;
      hakg_pkg::S_SEARCH: if (srch_done) state_next = hakg_pkg::S_DONE;
      hakg_pkg::S_DONE:   if (out_free) state_next = hakg_pkg::S_IDLE;
      default:            state_next = hakg_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_stall       = (state != hakg_pkg::S_IDLE);
    unit_req.start = 1'b0;
    unit_req.op    = hakg_pkg::OP_ROOT;
    srch_start     = 1'b0;
    load_out       = 1'b0;
    unique case (state)
      hakg_pkg::S_ROOT_K, hakg_pkg::S_ROOT_P: unit_req.start = !sent;
      hakg_pkg::S_DIV: begin
        unit_req.start = !sent;
        unit_req.op    = hakg_pkg::OP_DIV;
      end
      hakg_pkg::S_SEARCH: srch_start = !sent;
      hakg_pkg::S_DONE:   load_out = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= hakg_pkg::S_IDLE;
      sent       <= 1'b0;
      comp       <= '0;
      out_valid  <= 1'b0;
      kb_enabled <= 1'b1;
      angle_low  <= hakg_pkg::ANGLE_LOW_RST;
      angle_high <= hakg_pkg::ANGLE_HIGH_RST;
      tilt_limit <= hakg_pkg::TILT_LIMIT_RST;
    end else begin
      state <= state_next;
      if (unit_req.start || srch_start) begin
        sent <= 1'b1;
      end else if (unit_resp.done || srch_done) begin
        sent <= 1'b0;
      end
      if (accept) begin
        comp <= '0;
      end else if (state == hakg_pkg::S_SQUARE ||
                   (state == hakg_pkg::S_DIV && unit_resp.done)) begin
        comp <= (comp == 3'd5) ? 3'd0 : comp + 3'd1;
      end
      if (load_out) begin
        out_valid  <= 1'b1;
        kb_enabled <= en_c;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          hakg_pkg::CFG_ANGLE_LOW:  angle_low  <= cfg_data[8:0];
          hakg_pkg::CFG_ANGLE_HIGH: angle_high <= cfg_data[8:0];
          hakg_pkg::CFG_TILT_LIMIT: tilt_limit <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      wake   <= kind;
      sk     <= '0;
      sp     <= '0;
      mag[0] <= {4'b0, (kb_x[11] ? 12'(-kb_x) : 12'(kb_x))};
      mag[1] <= {4'b0, (kb_y[11] ? 12'(-kb_y) : 12'(kb_y))};
      mag[2] <= {4'b0, (kb_z[11] ? 12'(-kb_z) : 12'(kb_z))};
      mag[3] <= pad_x[15] ? 16'(-pad_x) : 16'(pad_x);
      mag[4] <= pad_y[15] ? 16'(-pad_y) : 16'(pad_y);
      mag[5] <= pad_z[15] ? 16'(-pad_z) : 16'(pad_z);
      neg[0] <= kb_x[11];
      neg[1] <= !kb_y[11] && kb_y != '0;
      neg[2] <= !kb_z[11] && kb_z != '0;
      neg[3] <= pad_x[15];
      neg[4] <= pad_y[15];
      neg[5] <= pad_z[15];
    end
    if (state == hakg_pkg::S_SQUARE) begin
      if (comp < 3'd3) begin
        sk <= sk + SW'(sq);
      end else begin
        sp <= sp + SW'(sq);
      end
    end
    if (unit_resp.done) begin
      if (state == hakg_pkg::S_ROOT_K) rk <= unit_resp.result;
      if (state == hakg_pkg::S_ROOT_P) rp <= unit_resp.result;
      if (state == hakg_pkg::S_DIV)    qn[comp] <= QW'(unit_resp.result);
    end
    if (load_out) begin
      hinge_angle  <= wake ? 9'd0 : 9'(best_i);
      angle_valid  <= !wake && valid_c;
      kb_enable    <= en_c;
      write_issued <= wake || (en_c != kb_enabled);
    end
  end

  hakg_rootdiv #(
    .FRAC_BITS(FRAC_BITS)
  ) u_rootdiv (
    .clk      (clk),
    .rst      (rst),
    .req      (unit_req),
    .radicand ({(state == hakg_pkg::S_ROOT_K) ? sk : sp, 32'b0} >> 2),
    .dividend (mag[comp]),
    .divisor  ((comp < 3'd3) ? rk : rp),
    .resp     (unit_resp)
  );

  always_comb begin
    kx_n    = neg[0] ? -$signed({1'b0, qn[0]}) : $signed({1'b0, qn[0]});
    kz_n    = neg[2] ? -$signed({1'b0, qn[2]}) : $signed({1'b0, qn[2]});
    px_n    = neg[3] ? -$signed({1'b0, qn[3]}) : $signed({1'b0, qn[3]});
    pz_n    = neg[5] ? -$signed({1'b0, qn[5]}) : $signed({1'b0, qn[5]});
    err     = (qn[1] > qn[4]) ? qn[1] : qn[4];
    valid_c = !((TCW'(err) << 15) > (TCW'(tilt_limit) << FRAC_BITS));
    en_c    = wake ? kb_enabled
                   : (valid_c && XW'(best_i) >= XW'(angle_low) && XW'(best_i) <= XW'(angle_high));
  end

  hakg_search #(
    .TABLE_ENTRIES(TABLE_ENTRIES),
    .ANGLE_STEPS  (ANGLE_STEPS),
    .FRAC_BITS    (FRAC_BITS)
  ) u_search (
    .clk   (clk),
    .rst   (rst),
    .start (srch_start),
    .kx    (kx_n),
    .kz    (kz_n),
    .px    (px_n),
    .pz    (pz_n),
    .done  (srch_done),
    .best_i(best_i)
  );

  a_unit_start_idle: assert property (@(posedge clk) disable iff (rst)
    unit_req.start |-> !unit_resp.busy)
    else $error("root/divide unit started while busy");

  a_unit_done_state: assert property (@(posedge clk) disable iff (rst)
    unit_resp.done |-> (state == hakg_pkg::S_ROOT_K || state == hakg_pkg::S_ROOT_P ||
                        state == hakg_pkg::S_DIV))
    else $error("root/divide result outside its phase");

  a_search_done_state: assert property (@(posedge clk) disable iff (rst)
    srch_done |-> state == hakg_pkg::S_SEARCH)
    else $error("search finished outside search phase");

  a_load_then_valid: assert property (@(posedge clk) disable iff (rst)
    load_out |=> out_valid && state == hakg_pkg::S_IDLE)
    else $error("result transfer not presented after load");

endmodule
`default_nettype wire

// ===== test/hakg_checker.sv =====
// Checker for the hinge angle keyboard gate: predicts every result and compares it.
module hakg_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic               kind,
  input  logic signed [11:0] kb_x,
  input  logic signed [11:0] kb_y,
  input  logic signed [11:0] kb_z,
  input  logic signed [15:0] pad_x,
  input  logic signed [15:0] pad_y,
  input  logic signed [15:0] pad_z,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [8:0]         hinge_angle,
  input  logic               angle_valid,
  input  logic               kb_enable,
  input  logic               write_issued,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [14:0]        cfg_data,
  output int                 fails,
  output int                 pending
);

  localparam int QTR  = hakg_pkg::TABLE_ENTRIES_DEF - 1;
  localparam int FB   = hakg_pkg::FRAC_BITS_DEF;
  localparam longint ONE = longint'(1) << FB;

  typedef struct packed {
    logic [8:0] angle;
    logic       valid;
    logic       enable;
    logic       write;
  } gate_result_t;

  longint unsigned sine_rom [0:QTR];
  logic [8:0]      low_deg, high_deg;
  logic [14:0]     tilt_max;
  logic            kb_on;
  gate_result_t    expected_q[$];

  function automatic longint unsigned taylor_sine(input longint unsigned x);
    longint unsigned divs [6];
    longint unsigned x2, h, t;
    divs = '{156, 110, 72, 42, 20, 6};
    x2 = (x * x) >> 30;
    h = hakg_pkg::ONE_Q30;
    for (int k = 0; k < 6; k++) begin
      t = ((h * x2) >> 30) / divs[k];
      h = (t >= hakg_pkg::ONE_Q30) ? 0 : hakg_pkg::ONE_Q30 - t;
    end
    return (x * h) >> 30;
  endfunction

  function automatic longint unsigned int_root(input longint unsigned a);
    longint unsigned r, b;
    r = 0;
    b = longint'(1) << 62;
    while (b > a) b = b >> 2;
    while (b != 0) begin
      if (a >= r + b) begin
        a = a - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint unit_comp(input longint v, input longint unsigned r);
    longint unsigned a, qv;
    if (r == 0) return 0;
    a = (v < 0) ? -v : v;
    qv = (a << (FB + 15)) / r;
    if (qv > ONE) qv = ONE;
    return (v < 0) ? -longint'(qv) : longint'(qv);
  endfunction

  function automatic longint unsigned magn(input longint v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic gate_result_t gate_predict(input longint ax, ay, az, bx, by, bz);
    gate_result_t    res;
    longint unsigned rk, rp, cost, best, err;
    longint          kx, ky, kz, px, py, pz, c, s, d1, d2;
    int              best_i, m, j;
    logic            cn, sn, ok, en;
    rk = int_root(longint'(ax * ax + ay * ay + az * az) << 30);
    rp = int_root(longint'(bx * bx + by * by + bz * bz) << 30);
    kx = unit_comp(ax, rk); ky = unit_comp(ay, rk); kz = unit_comp(az, rk);
    px = unit_comp(bx, rp); py = unit_comp(by, rp); pz = unit_comp(bz, rp);
    best = '1;
    best_i = 0;
    for (int i = 0; i < hakg_pkg::ANGLE_STEPS_DEF; i++) begin
      m = i % (4 * QTR);
      cn = 0; sn = 0;
      if (m <= QTR) j = m;
      else if (m <= 2 * QTR) begin j = 2 * QTR - m; cn = 1; end
      else if (m <= 3 * QTR) begin j = m - 2 * QTR; cn = 1; sn = 1; end
      else begin j = 4 * QTR - m; sn = 1; end
      c = sine_rom[QTR - j];
      s = sine_rom[j];
      if (cn) c = -c;
      if (sn) s = -s;
      d1 = c * kx - s * kz + px * ONE;
      d2 = c * kz + s * kx + pz * ONE;
      cost = magn(d1) + magn(d2);
      if (cost < best) begin
        best = cost;
        best_i = i;
      end
    end
    err = (magn(ky) > magn(py)) ? magn(ky) : magn(py);
    ok = !((err << 15) > (longint'(tilt_max) << FB));
    en = ok && best_i >= low_deg && best_i <= high_deg;
    res.angle = best_i[8:0];
    res.valid = ok;
    res.enable = en;
    res.write = (en != kb_on);
    kb_on = en;
    return res;
  endfunction

  initial begin
    longint unsigned v, x;
    for (int k = 0; k <= QTR; k++) begin
      x = (hakg_pkg::HALF_PI_Q30 * k + QTR / 2) / QTR;
      v = taylor_sine(x);
      v = (v + ((longint'(1) << (30 - FB)) >> 1)) >> (30 - FB);
      if (v > ONE) v = ONE;
      sine_rom[k] = v;
    end
    sine_rom[0] = 0;
    sine_rom[QTR] = ONE;
    fails = 0;
  end

  assign pending = expected_q.size();

  always @(posedge clk) begin
    gate_result_t e, got;
    if (rst) begin
      low_deg <= hakg_pkg::ANGLE_LOW_RST;
      high_deg <= hakg_pkg::ANGLE_HIGH_RST;
      tilt_max <= hakg_pkg::TILT_LIMIT_RST;
      kb_on = 1'b1;
      expected_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          hakg_pkg::CFG_ANGLE_LOW:  low_deg <= cfg_data[8:0];
          hakg_pkg::CFG_ANGLE_HIGH: high_deg <= cfg_data[8:0];
          hakg_pkg::CFG_TILT_LIMIT: tilt_max <= cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        if (kind) begin
          e = '{angle: 9'd0, valid: 1'b0, enable: kb_on, write: 1'b1};
        end else begin
          e = gate_predict(kb_x, -longint'(kb_y), -longint'(kb_z), pad_x, pad_y, pad_z);
        end
        expected_q.push_back(e);
      end
      if (out_valid && !out_stall) begin
        got = '{angle: hinge_angle, valid: angle_valid, enable: kb_enable,
                write: write_issued};
        if (expected_q.size() == 0) begin
          $error("result transfer with nothing expected");
          fails++;
        end else begin
          e = expected_q.pop_front();
          if (got.angle !== e.angle) begin
            $error("hinge_angle expected %0d actual %0d", e.angle, got.angle);
            fails++;
          end
          if (got.valid !== e.valid) begin
            $error("angle_valid expected %0d actual %0d", e.valid, got.valid);
            fails++;
          end
          if (got.enable !== e.enable) begin
            $error("kb_enable expected %0d actual %0d", e.enable, got.enable);
            fails++;
          end
          if (got.write !== e.write) begin
            $error("write_issued expected %0d actual %0d", e.write, got.write);
            fails++;
          end
        end
      end
    end
  end
endmodule

// ===== test/hinge_angle_keyboard_gate_test.sv =====
// Testbench top: drives samples, wake requests and register writes into the gate.
module hinge_angle_keyboard_gate_test;

  logic               clk = 0;
  logic               rst = 1;
  logic               in_valid = 0;
  logic               in_stall;
  logic               kind = 0;
  logic signed [11:0] kb_x = 0, kb_y = 0, kb_z = 0;
  logic signed [15:0] pad_x = 0, pad_y = 0, pad_z = 0;
  logic               out_valid;
  logic               out_stall = 0;
  logic [8:0]         hinge_angle;
  logic               angle_valid, kb_enable, write_issued;
  logic               cfg_we = 0;
  logic [1:0]         cfg_index = hakg_pkg::CFG_ANGLE_LOW;
  logic [14:0]        cfg_data = 0;
  int                 fails, pending;
  bit                 calm = 0;

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  hinge_angle_keyboard_gate uut (.*);

  hakg_checker chk (.*);

  always @(posedge clk) begin
    out_stall <= calm ? 1'b0 : ($urandom_range(99) < 18);
  end

  task automatic send(input logic k, input int ax, ay, az, bx, by, bz);
    if (!calm && $urandom_range(99) < 18) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1;
    kind <= k;
    kb_x <= 12'(ax); kb_y <= 12'(ay); kb_z <= 12'(az);
    pad_x <= 16'(bx); pad_y <= 16'(by); pad_z <= 16'(bz);
    do @(posedge clk); while (in_stall);
  endtask

  task automatic drain;
    in_valid <= 0;
    do @(posedge clk); while (pending != 0);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [14:0] val);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 0;
  endtask

  task automatic rand_item(input int n);
    int sh;
    sh = $urandom_range(0, 11);
    if ($urandom_range(99) < 8) begin
      send(1, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    end else if ($urandom_range(99) < 25) begin
      send(0, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    end else begin
      send(0, $signed(12'($urandom)) >>> (sh / 2), $urandom_range(0, 60) - 30,
           $signed(12'($urandom)) >>> (sh / 2), $signed(16'($urandom)) >>> sh,
           $urandom_range(0, 400) - 200, $signed(16'($urandom)) >>> sh);
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    send(0, 0, 0, 0, 0, 0, 0);
    send(1, -2048, 2047, -1, 32767, -32768, 5);
    send(0, 2047, 0, 0, -32768, 0, 0);
    send(0, -2048, 0, 0, 32767, 0, 0);
    send(0, 0, 0, 2047, 0, 0, -32768);
    send(0, 0, 0, -2048, 0, 0, 32767);
    send(0, 0, 2047, 0, 0, 0, 2560);
    send(0, 0, -2048, 0, 0, -32768, 0);
    send(0, 2047, 2047, 2047, 32767, 32767, 32767);
    send(0, -2048, -2048, -2048, -32768, -32768, -32768);
    send(0, 1000, 0, 0, 0, 0, 2560);
    send(0, 0, 0, 1000, 2560, 0, 0);
    send(0, 700, 5, -700, -1800, 3, 1800);
    send(0, -700, 0, 700, 1800, 0, 1800);
    send(1, 0, 0, 0, 0, 0, 0);
    send(0, 1, -1, 1, 1, -1, 1);
    send(0, 1000, 1000, 0, 0, 0, 2560);
    drain();
    write_reg(hakg_pkg::CFG_ANGLE_LOW, 15'd0);
    write_reg(hakg_pkg::CFG_ANGLE_HIGH, 15'd360);
    write_reg(hakg_pkg::CFG_TILT_LIMIT, 15'd32767);
    write_reg(2'd3, 15'h7fff);
    for (int n = 0; n < 100; n++) rand_item(n);
    drain();
    write_reg(hakg_pkg::CFG_ANGLE_LOW, 15'd360);
    write_reg(hakg_pkg::CFG_ANGLE_HIGH, 15'd0);
    write_reg(hakg_pkg::CFG_TILT_LIMIT, 15'd0);
    send(0, 0, 0, 0, 0, 0, 0);
    for (int n = 0; n < 40; n++) rand_item(n);
    drain();
    write_reg(hakg_pkg::CFG_ANGLE_LOW, 15'h7fff);
    write_reg(hakg_pkg::CFG_ANGLE_HIGH, 15'h7fff);
    write_reg(hakg_pkg::CFG_TILT_LIMIT, 15'd16384);
    calm = 1;
    for (int n = 0; n < 80; n++) rand_item(n);
    calm = 0;
    drain();
    write_reg(hakg_pkg::CFG_ANGLE_LOW, 15'd40);
    write_reg(hakg_pkg::CFG_ANGLE_HIGH, 15'd230);
    write_reg(hakg_pkg::CFG_TILT_LIMIT, 15'd32113);
    for (int n = 0; n < 100; n++) rand_item(n);
    drain();
    write_reg(hakg_pkg::CFG_ANGLE_LOW, 15'($urandom_range(0, 180)));
    write_reg(hakg_pkg::CFG_ANGLE_HIGH, 15'($urandom_range(180, 360)));
    write_reg(hakg_pkg::CFG_TILT_LIMIT, 15'($urandom_range(20000, 32767)));
    for (int n = 0; n < 80; n++) rand_item(n);
    drain();
    repeat (20) @(posedge clk);
    if (fails == 0) begin
      $display("hinge_angle_keyboard_gate_test: PASS");
    end else begin
      $display("hinge_angle_keyboard_gate_test: FAIL");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("hinge_angle_keyboard_gate_test: FAIL");
    $finish;
  end
endmodule
